@@ sv/tb2d_pkg.sv @@
`timescale 1ns / 1ps

package tb2d_pkg;

  // Fixed field widths of the Q16.16 datapath.
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int WGT_W  = 17;

  // Weight that selects the upper point entirely.
  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_WR_COL = 2'd0;
  localparam logic [1:0] OP_WR_ROW = 2'd1;
  localparam logic [1:0] OP_WR_CELL = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_COL_COUNT = 1'b0;
  localparam logic CFG_ROW_COUNT = 1'b1;

  // Operands of one weight division: (num << 16) / den.
  typedef struct packed {
    logic signed [VAL_W:0] num;
    logic signed [VAL_W:0] den;
  } div_req_t;

  // Operands of one blend: a + (((b - a) * w) >>> 16).
  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic [WGT_W-1:0]        w;
  } blend_req_t;

endpackage

@@ sv/tb2d_div.sv @@
`timescale 1ns / 1ps

module tb2d_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  tb2d_pkg::div_req_t           req,
  output logic                         done,
  output logic [tb2d_pkg::WGT_W-1:0]   quo
);

  logic                          run;
  logic [3:0]                    cnt;
  logic [tb2d_pkg::VAL_W:0]      rem;
  logic [tb2d_pkg::VAL_W:0]      dmag;
  logic                          num_neg;
  logic                          den_neg;
  logic [tb2d_pkg::VAL_W:0]      num_mag;
  logic [tb2d_pkg::VAL_W:0]      den_mag;
  logic [tb2d_pkg::VAL_W+1:0]    rem_sh;
  logic [tb2d_pkg::VAL_W+1:0]    rem_sub;
  logic                          fits;

  // Magnitudes of the operands; the quotient sign only decides saturation.
  assign num_neg = req.num[tb2d_pkg::VAL_W];
  assign den_neg = req.den[tb2d_pkg::VAL_W];
  assign num_mag = num_neg ? (tb2d_pkg::VAL_W+1)'(-req.num) : (tb2d_pkg::VAL_W+1)'(req.num);
  assign den_mag = den_neg ? (tb2d_pkg::VAL_W+1)'(-req.den) : (tb2d_pkg::VAL_W+1)'(req.den);

  // One restoring step: shift the remainder and try the divisor.
  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, dmag};
  assign fits    = rem_sh >= {1'b0, dmag};

  // Saturating cases finish at once; otherwise sixteen quotient bits follow.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (req.den == '0 || req.num == '0 || num_neg != den_neg) begin
          quo  <= '0;
          done <= 1'b1;
        end else if (num_mag >= den_mag) begin
          quo  <= tb2d_pkg::WGT_ONE;
          done <= 1'b1;
        end else begin
          run  <= 1'b1;
          cnt  <= '0;
          rem  <= num_mag;
          dmag <= den_mag;
          quo  <= '0;
        end
      end else if (run) begin
        rem <= fits ? rem_sub[tb2d_pkg::VAL_W:0] : rem_sh[tb2d_pkg::VAL_W:0];
        quo <= {quo[tb2d_pkg::WGT_W-2:0], fits};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A new division is never started while one is still iterating.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) start |-> !run)
    else $error("divider started while busy");

endmodule

@@ sv/tb2d_blend.sv @@
`timescale 1ns / 1ps

module tb2d_blend (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  tb2d_pkg::blend_req_t                req,
  output logic                                done,
  output logic signed [tb2d_pkg::VAL_W-1:0]   res
);

  logic                                 v1;
  logic                                 v2;
  logic signed [tb2d_pkg::VAL_W-1:0]    a1;
  logic signed [tb2d_pkg::VAL_W:0]      d1;
  logic [tb2d_pkg::WGT_W-1:0]           w1;
  logic signed [tb2d_pkg::VAL_W-1:0]    a2;
  logic signed [50:0]                   p2;
  logic signed [50:0]                   q2;

  // Floor shift of the product drops the fraction bits.
  assign q2 = p2 >>> tb2d_pkg::FRAC_W;

  // Difference, product and sum each take one register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
      a1   <= req.a;
      d1   <= $signed({req.b[tb2d_pkg::VAL_W-1], req.b}) -
              $signed({req.a[tb2d_pkg::VAL_W-1], req.a});
      w1   <= req.w;
      a2   <= a1;
      p2   <= d1 * $signed({1'b0, w1});
      res  <= a2 + q2[tb2d_pkg::VAL_W-1:0];
    end
  end

endmodule

@@ sv/table_bilinear_2d_unit.sv @@
`timescale 1ns / 1ps
// A lookup clamps both coordinates, runs S = ceil(log2(larger count in use)) binary search
// steps, divides for the x and y weights, reads the corners and blends. A weight division that
// saturates or has a zero span skips the iteration, else it gives one quotient bit per cycle.
// One lookup at a time, busy is high throughout; axis and cell writes give no result.
// Reset clears the control and sets both counts to 2; axis and cell memories hold garbage
// until written.
module table_bilinear_2d_unit #(
  parameter int AXIS_POINTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [4:0]         col_index,
  input  logic [4:0]         row_index,
  input  logic signed [31:0] write_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [4:0]         found_col,
  output logic [4:0]         found_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int IW = $clog2(AXIS_POINTS);
  localparam int CW = $clog2(AXIS_POINTS + 1);
  localparam int MW = CW + 1;
  localparam int AW = $clog2(AXIS_POINTS * AXIS_POINTS);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_CLAMP_LO  = 5'd1;
  localparam logic [4:0] S_CLAMP_HI  = 5'd2;
  localparam logic [4:0] S_CLAMP_FIN = 5'd3;
  localparam logic [4:0] S_SRCH_RD   = 5'd4;
  localparam logic [4:0] S_SRCH_CMP  = 5'd5;
  localparam logic [4:0] S_SRCH_FIX  = 5'd6;
  localparam logic [4:0] S_SPAN_LO   = 5'd7;
  localparam logic [4:0] S_SPAN_HI   = 5'd8;
  localparam logic [4:0] S_SPAN_GET  = 5'd9;
  localparam logic [4:0] S_DIVX_GO   = 5'd10;
  localparam logic [4:0] S_DIVX_WAIT = 5'd11;
  localparam logic [4:0] S_DIVY_GO   = 5'd12;
  localparam logic [4:0] S_DIVY_WAIT = 5'd13;
  localparam logic [4:0] S_CELL0     = 5'd14;
  localparam logic [4:0] S_CELL1     = 5'd15;
  localparam logic [4:0] S_CELL2     = 5'd16;
  localparam logic [4:0] S_CELL3     = 5'd17;
  localparam logic [4:0] S_CELL4     = 5'd18;
  localparam logic [4:0] S_BLT_GO    = 5'd19;
  localparam logic [4:0] S_BLT_WAIT  = 5'd20;
  localparam logic [4:0] S_BLB_GO    = 5'd21;
  localparam logic [4:0] S_BLB_WAIT  = 5'd22;
  localparam logic [4:0] S_BLR_GO    = 5'd23;
  localparam logic [4:0] S_BLR_WAIT  = 5'd24;

  logic [4:0]         state;
  logic [5:0]         col_count;
  logic [5:0]         row_count;
  logic               accept;

  logic signed [31:0] col_mem [AXIS_POINTS];
  logic signed [31:0] row_mem [AXIS_POINTS];
  logic signed [31:0] cell_mem [AXIS_POINTS * AXIS_POINTS];
  logic signed [31:0] cell_q;
  logic [AW-1:0]      cell_raddr;
  logic [AW-1:0]      cell_waddr;

  logic [CW-1:0]      n_use [2];
  logic signed [31:0] v [2];
  logic signed [31:0] lo [2];
  logic signed [31:0] hi [2];
  logic signed [31:0] axq [2];
  logic [IW-1:0]      raddr [2];
  logic [CW-1:0]      lower [2];
  logic [CW-1:0]      len [2];
  logic [MW-1:0]      mid [2];
  logic [CW-1:0]      lower_next [2];
  logic [CW-1:0]      len_next [2];
  logic [MW-1:0]      mid_next [2];
  logic               search_end;

  logic signed [31:0] corner [4];
  logic signed [31:0] top;
  logic signed [31:0] bot;
  logic [16:0]        wx;
  logic [16:0]        wy;

  logic                 div_start;
  logic                 div_done;
  logic                 div_sel;
  logic [16:0]          div_quo;
  tb2d_pkg::div_req_t   div_req;
  logic                 bl_start;
  logic                 bl_done;
  logic signed [31:0]   bl_res;
  tb2d_pkg::blend_req_t bl_req;

  // Count register saturated to the range of usable axis points.
  function automatic logic [CW-1:0] count_use(input logic [5:0] r);
    logic [CW-1:0] c;
    if (r < 6'd2) begin
      c = CW'(2);
    end else if (32'(r) > AXIS_POINTS) begin
      c = CW'(AXIS_POINTS);
    end else begin
      c = CW'(r);
    end
    return c;
  endfunction

  // Row-major cell address.
  function automatic logic [AW-1:0] cell_addr(input logic [MW-1:0] r, input logic [MW-1:0] c);
    return AW'(int'(r) * AXIS_POINTS + int'(c));
  endfunction

  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign n_use[0]  = count_use(col_count);
  assign n_use[1]  = count_use(row_count);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= 6'd2;
      row_count <= 6'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tb2d_pkg::CFG_COL_COUNT: col_count <= cfg_data;
        tb2d_pkg::CFG_ROW_COUNT: row_count <= cfg_data;
      endcase
    end
  end

  // Axis read addresses for each phase of the lookup.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      case (state)
        S_CLAMP_HI: raddr[k] = IW'(n_use[k] - CW'(1));
        S_SRCH_RD:  raddr[k] = IW'(mid[k]);
        S_SPAN_LO:  raddr[k] = IW'(lower[k]);
        S_SPAN_HI:  raddr[k] = IW'(lower[k] + CW'(1));
        default:    raddr[k] = '0;
      endcase
    end
  end

  // Axis memories: one write port from input beats, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && op == tb2d_pkg::OP_WR_COL && 32'(col_index) < AXIS_POINTS) begin
      col_mem[IW'(col_index)] <= write_value;
    end
    if (accept && op == tb2d_pkg::OP_WR_ROW && 32'(row_index) < AXIS_POINTS) begin
      row_mem[IW'(row_index)] <= write_value;
    end
    axq[0] <= col_mem[raddr[0]];
    axq[1] <= row_mem[raddr[1]];
  end

  // Cell writes use the index ports; reads take the four corners of the found lower cell.
  assign cell_waddr = cell_addr(MW'(row_index), MW'(col_index));

  always_comb begin
    case (state)
      S_CELL1: cell_raddr = cell_addr(MW'(lower[1]), MW'(lower[0]) + MW'(1));
      S_CELL2: cell_raddr = cell_addr(MW'(lower[1]) + MW'(1), MW'(lower[0]));
      S_CELL3: cell_raddr = cell_addr(MW'(lower[1]) + MW'(1), MW'(lower[0]) + MW'(1));
      default: cell_raddr = cell_addr(MW'(lower[1]), MW'(lower[0]));
    endcase
  end

  // Cell memory with a registered read.
  always_ff @(posedge clk) begin
    if (accept && op == tb2d_pkg::OP_WR_CELL && 32'(col_index) < AXIS_POINTS &&
        32'(row_index) < AXIS_POINTS) begin
      cell_mem[cell_waddr] <= write_value;
    end
    cell_q <= cell_mem[cell_raddr];
  end

  // One binary search step per axis; a probe at or past the count does not move.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lower_next[k] = lower[k];
      len_next[k]   = len[k];
      if (len[k] > CW'(1)) begin
        if (mid[k] < MW'(n_use[k]) && v[k] > axq[k]) begin
          lower_next[k] = CW'(mid[k]);
        end
        len_next[k] = CW'((MW'(len[k]) + MW'(1)) >> 1);
      end
      mid_next[k] = MW'(lower_next[k]) + MW'(len_next[k] >> 1);
    end
  end

  assign search_end = (len_next[0] <= CW'(1)) && (len_next[1] <= CW'(1));

  // Operands of the shared divider and blend units.
  assign div_sel   = state == S_DIVY_GO;
  assign div_start = state == S_DIVX_GO || state == S_DIVY_GO;

  always_comb begin
    div_req.num = $signed({v[div_sel][31], v[div_sel]}) -
                  $signed({lo[div_sel][31], lo[div_sel]});
    div_req.den = $signed({hi[div_sel][31], hi[div_sel]}) -
                  $signed({lo[div_sel][31], lo[div_sel]});
  end

  assign bl_start = state == S_BLT_GO || state == S_BLB_GO || state == S_BLR_GO;

  always_comb begin
    case (state)
      S_BLB_GO: begin
        bl_req.a = corner[2];
        bl_req.b = corner[3];
        bl_req.w = wx;
      end
      S_BLR_GO: begin
        bl_req.a = top;
        bl_req.b = bot;
        bl_req.w = wy;
      end
      default: begin
        bl_req.a = corner[0];
        bl_req.b = corner[1];
        bl_req.w = wx;
      end
    endcase
  end

  tb2d_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  tb2d_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (bl_start),
    .req   (bl_req),
    .done  (bl_done),
    .res   (bl_res)
  );

  // Lookup sequencer and its datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && op == tb2d_pkg::OP_LOOKUP) begin
            v[0]  <= coord_x;
            v[1]  <= coord_y;
            state <= S_CLAMP_LO;
          end
        end
        S_CLAMP_LO: state <= S_CLAMP_HI;
        S_CLAMP_HI: begin
          for (int k = 0; k < 2; k++) begin
            if (v[k] < axq[k]) v[k] <= axq[k];
          end
          state <= S_CLAMP_FIN;
        end
        S_CLAMP_FIN: begin
          for (int k = 0; k < 2; k++) begin
            if (v[k] > axq[k]) v[k] <= axq[k];
            lower[k] <= '0;
            len[k]   <= n_use[k];
            mid[k]   <= MW'(n_use[k] >> 1);
          end
          state <= S_SRCH_RD;
        end
        S_SRCH_RD: state <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          for (int k = 0; k < 2; k++) begin
            lower[k] <= lower_next[k];
            len[k]   <= len_next[k];
            mid[k]   <= mid_next[k];
          end
          state <= search_end ? S_SRCH_FIX : S_SRCH_RD;
        end
        S_SRCH_FIX: begin
          for (int k = 0; k < 2; k++) begin
            if (lower[k] > n_use[k] - CW'(2)) lower[k] <= n_use[k] - CW'(2);
          end
          state <= S_SPAN_LO;
        end
        S_SPAN_LO: state <= S_SPAN_HI;
        S_SPAN_HI: begin
          lo[0] <= axq[0];
          lo[1] <= axq[1];
          state <= S_SPAN_GET;
        end
        S_SPAN_GET: begin
          hi[0] <= axq[0];
          hi[1] <= axq[1];
          state <= S_DIVX_GO;
        end
        S_DIVX_GO: state <= S_DIVX_WAIT;
        S_DIVX_WAIT: begin
          if (div_done) begin
            wx    <= div_quo;
            state <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: state <= S_DIVY_WAIT;
        S_DIVY_WAIT: begin
          if (div_done) begin
            wy    <= div_quo;
            state <= S_CELL0;
          end
        end
        S_CELL0: state <= S_CELL1;
        S_CELL1: begin
          corner[0] <= cell_q;
          state     <= S_CELL2;
        end
        S_CELL2: begin
          corner[1] <= cell_q;
          state     <= S_CELL3;
        end
        S_CELL3: begin
          corner[2] <= cell_q;
          state     <= S_CELL4;
        end
        S_CELL4: begin
          corner[3] <= cell_q;
          state     <= S_BLT_GO;
        end
        S_BLT_GO: state <= S_BLT_WAIT;
        S_BLT_WAIT: begin
          if (bl_done) begin
            top   <= bl_res;
            state <= S_BLB_GO;
          end
        end
        S_BLB_GO: state <= S_BLB_WAIT;
        S_BLB_WAIT: begin
          if (bl_done) begin
            bot   <= bl_res;
            state <= S_BLR_GO;
          end
        end
        S_BLR_GO: state <= S_BLR_WAIT;
        S_BLR_WAIT: begin
          if (bl_done) begin
            result_value <= bl_res;
            found_col    <= 5'(lower[0]);
            found_row    <= 5'(lower[1]);
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result beat only follows the final blend.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_BLR_WAIT)
    else $error("result beat without a finished blend");

  // The search leaves lower cells that have an upper neighbor.
  a_lower_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_SPAN_LO |-> (lower[0] <= n_use[0] - CW'(2) && lower[1] <= n_use[1] - CW'(2)))
    else $error("lower cell beyond count");

  // A lookup only begins from an accepted lookup beat.
  a_lookup_start: assert property (@(posedge clk) disable iff (rst)
    state == S_CLAMP_LO |-> $past(accept) && $past(op) == tb2d_pkg::OP_LOOKUP)
    else $error("lookup began without a lookup beat");

endmodule

@@ bench/table_bilinear_2d_unit_tb.sv @@
`timescale 1ns / 1ps

module table_bilinear_2d_unit_tb;

  localparam int POINTS = 32;
  localparam int CYCLE_LIMIT = 2000000;
  // Longer than the longest lookup; waited out before touching the counts.
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic signed [31:0] value;
    logic [4:0]         col;
    logic [4:0]         row;
  } lookup_result_t;

  // Scoreboard: mirrors the table state and queues the blend expected for each lookup.
  class lookup_scoreboard;
    logic [5:0] col_reg;
    logic [5:0] row_reg;
    int col_ax[POINTS];
    int row_ax[POINTS];
    int cells[POINTS*POINTS];
    bit col_written[POINTS];
    bit row_written[POINTS];
    bit cell_written[POINTS*POINTS];
    lookup_result_t pending_results[$];
    int errors;
    int lookups_checked;
    int writes_seen;

    function new();
      col_reg = 6'd2;
      row_reg = 6'd2;
      errors = 0;
      lookups_checked = 0;
      writes_seen = 0;
    endfunction

    function int points_in_use(logic [5:0] r);
      if (r < 2) return 2;
      if (r > POINTS) return POINTS;
      return r;
    endfunction

    function void note_config(logic idx, logic [5:0] data);
      if (idx == tb2d_pkg::CFG_COL_COUNT) col_reg = data;
      else row_reg = data;
    endfunction

    function longint clamp_axis(int ax[POINTS], int n, longint v);
      if (v < longint'(ax[0])) v = ax[0];
      if (v > longint'(ax[n-1])) v = ax[n-1];
      return v;
    endfunction

    // Binary search for the lower cell; probes at or past the count stay put.
    function int lower_point(int ax[POINTS], int n, longint v);
      int lower;
      int span_len;
      int mid;
      lower = 0;
      span_len = n;
      mid = span_len / 2;
      while (span_len > 1) begin
        if (mid < n && v > longint'(ax[mid])) lower = mid;
        span_len = (span_len + 1) / 2;
        mid = lower + span_len / 2;
      end
      if (lower > n - 2) lower = n - 2;
      return lower;
    endfunction

    function longint weight(longint v, longint lo, longint hi);
      longint span;
      longint w;
      span = hi - lo;
      if (span == 0) return 0;
      w = ((v - lo) * 65536) / span;
      if (w < 0) w = 0;
      if (w > 65536) w = 65536;
      return w;
    endfunction

    function longint mix(longint a, longint b, longint w);
      longint p;
      p = (b - a) * w;
      return a + (p >>> 16);
    endfunction

    // Called for each accepted input beat.
    function void note_beat(logic [1:0] op, logic [4:0] ci, logic [4:0] ri,
                            logic signed [31:0] wv, logic signed [31:0] cx,
                            logic signed [31:0] cy);
      int nc;
      int nr;
      int fc;
      int fr;
      longint x;
      longint y;
      longint wx;
      longint wy;
      longint upper;
      longint lower_row;
      longint res;
      lookup_result_t r;
      case (op)
        tb2d_pkg::OP_WR_COL: begin
          col_ax[ci] = wv;
          col_written[ci] = 1;
          writes_seen++;
        end
        tb2d_pkg::OP_WR_ROW: begin
          row_ax[ri] = wv;
          row_written[ri] = 1;
          writes_seen++;
        end
        tb2d_pkg::OP_WR_CELL: begin
          cells[ri*POINTS + ci] = wv;
          cell_written[ri*POINTS + ci] = 1;
          writes_seen++;
        end
        default: begin
          nc = points_in_use(col_reg);
          nr = points_in_use(row_reg);
          x = clamp_axis(col_ax, nc, longint'(cx));
          y = clamp_axis(row_ax, nr, longint'(cy));
          fc = lower_point(col_ax, nc, x);
          fr = lower_point(row_ax, nr, y);
          wx = weight(x, col_ax[fc], col_ax[fc+1]);
          wy = weight(y, row_ax[fr], row_ax[fr+1]);
          upper = mix(cells[fr*POINTS + fc], cells[fr*POINTS + fc + 1], wx);
          lower_row = mix(cells[(fr+1)*POINTS + fc], cells[(fr+1)*POINTS + fc + 1], wx);
          res = mix(upper, lower_row, wy);
          r.value = res[31:0];
          r.col = fc[4:0];
          r.row = fr[4:0];
          pending_results.push_back(r);
        end
      endcase
    endfunction

    // Called for each result beat.
    function void check_result(logic signed [31:0] v, logic [4:0] fc, logic [4:0] fr);
      lookup_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with no lookup outstanding: value %0d", v);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      lookups_checked++;
      if (v !== e.value) begin
        $error("result_value mismatch: expected %0d, got %0d", e.value, v);
        errors++;
      end
      if (fc !== e.col) begin
        $error("found_col mismatch: expected %0d, got %0d", e.col, fc);
        errors++;
      end
      if (fr !== e.row) begin
        $error("found_row mismatch: expected %0d, got %0d", e.row, fr);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         op;
  logic [4:0]         col_index;
  logic [4:0]         row_index;
  logic signed [31:0] write_value;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic               done;
  logic signed [31:0] result_value;
  logic [4:0]         found_col;
  logic [4:0]         found_row;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [5:0]         cfg_data;

  lookup_scoreboard sb;
  int cycles;
  bit quiet;
  int configs_done;

  table_bilinear_2d_unit #(.AXIS_POINTS(POINTS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .col_index(col_index), .row_index(row_index), .write_value(write_value),
    .coord_x(coord_x), .coord_y(coord_y), .done(done), .result_value(result_value),
    .found_col(found_col), .found_row(found_row), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Result monitor: a strobed beat is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result_value, found_col, found_row);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drive one beat and hold it until the block takes it; start stays high afterward unless an idle gap follows.
  task automatic send_beat(logic [1:0] o, logic [4:0] ci, logic [4:0] ri,
                           logic signed [31:0] wv, logic signed [31:0] cx,
                           logic signed [31:0] cy);
    int gap;
    start <= 1'b1;
    op <= o;
    col_index <= ci;
    row_index <= ri;
    write_value <= wv;
    coord_x <= cx;
    coord_y <= cy;
    do @(posedge clk); while (busy);
    sb.note_beat(o, ci, ri, wv, cx, cy);
    // Random bursts of idle on the input side.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic lookup(logic signed [31:0] cx, logic signed [31:0] cy);
    send_beat(tb2d_pkg::OP_LOOKUP, 5'd0, 5'd0, 32'sd0, cx, cy);
  endtask

  // Counts change only with the block idle and every result back.
  task automatic write_count(logic idx, logic [5:0] data);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    cfg_valid <= 1'b0;
    configs_done++;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Load fresh non-decreasing axes over the region in use and fill any unwritten cells,
  // so that no lookup can read an entry that was never written.
  task automatic load_region();
    int nc;
    int nr;
    int base;
    int step;
    nc = sb.points_in_use(sb.col_reg);
    nr = sb.points_in_use(sb.row_reg);
    base = $urandom_range(0, 1 << 30) - (1 << 30);
    for (int i = 0; i < nc; i++) begin
      step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << 24);
      send_beat(tb2d_pkg::OP_WR_COL, 5'(i), 5'($urandom), base, $urandom, $urandom);
      base += step;
    end
    base = $urandom_range(0, 1 << 30) - (1 << 30);
    for (int i = 0; i < nr; i++) begin
      step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << 20);
      send_beat(tb2d_pkg::OP_WR_ROW, 5'($urandom), 5'(i), base, $urandom, $urandom);
      base += step;
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (!sb.cell_written[r*POINTS + c])
          send_beat(tb2d_pkg::OP_WR_CELL, 5'(c), 5'(r), rand_word(), $urandom, $urandom);
  endtask

  // Pick a coordinate that mostly lands inside the axis span.
  function automatic logic signed [31:0] pick_coord(int ax[POINTS], int n);
    longint lo;
    longint hi;
    longint v;
    case ($urandom_range(0, 9))
      0: return rand_word();
      1, 2: return ax[$urandom_range(0, n - 1)];
      default: begin
        lo = ax[0];
        hi = ax[n-1];
        if (hi < lo) begin
          v = lo;
          lo = hi;
          hi = v;
        end
        lo -= 1000;
        hi += 1000;
        v = lo + (longint'($urandom) % (hi - lo + 1));
        if (v > 64'sh7fffffff) v = 64'sh7fffffff;
        if (v < -64'sh80000000) v = -64'sh80000000;
        return v[31:0];
      end
    endcase
  endfunction

  // Random mix of lookups and writes anywhere in storage.
  task automatic random_items(int count);
    int nc;
    int nr;
    int i;
    longint lo;
    longint hi;
    logic signed [31:0] v;
    for (int k = 0; k < count; k++) begin
      nc = sb.points_in_use(sb.col_reg);
      nr = sb.points_in_use(sb.row_reg);
      case ($urandom_range(0, 9))
        0, 1: begin
          // Axis point; usually kept between its neighbors.
          i = $urandom_range(0, 31);
          v = rand_word();
          if (i > 0 && i < 31 && $urandom_range(0, 4) != 0) begin
            lo = sb.col_ax[i-1];
            hi = sb.col_ax[i+1];
            if (hi >= lo) v = lo + (longint'($urandom) % (hi - lo + 1));
          end
          send_beat(tb2d_pkg::OP_WR_COL, 5'(i), 5'($urandom), v, $urandom, $urandom);
        end
        2: begin
          i = $urandom_range(0, 31);
          v = rand_word();
          if (i > 0 && i < 31 && $urandom_range(0, 4) != 0) begin
            lo = sb.row_ax[i-1];
            hi = sb.row_ax[i+1];
            if (hi >= lo) v = lo + (longint'($urandom) % (hi - lo + 1));
          end
          send_beat(tb2d_pkg::OP_WR_ROW, 5'($urandom), 5'(i), v, $urandom, $urandom);
        end
        3, 4:
          send_beat(tb2d_pkg::OP_WR_CELL, 5'($urandom), 5'($urandom), rand_word(),
                    $urandom, $urandom);
        default:
          lookup(pick_coord(sb.col_ax, nc), pick_coord(sb.row_ax, nr));
      endcase
    end
  endtask

  initial begin
    logic [5:0] col_settings[8];
    logic [5:0] row_settings[8];
    sb = new();
    cycles = 0;
    quiet = 0;
    configs_done = 0;
    rst = 1'b1;
    start = 1'b0;
    op = tb2d_pkg::OP_WR_COL;
    col_index = '0;
    row_index = '0;
    write_value = '0;
    coord_x = '0;
    coord_y = '0;
    cfg_valid = 1'b0;
    cfg_index = tb2d_pkg::CFG_COL_COUNT;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the 2 x 2 grid left by reset.
    send_beat(tb2d_pkg::OP_WR_COL, 5'd0, 5'd31, -32'sd65536, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_COL, 5'd1, 5'd0, 32'sd65536, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_ROW, 5'd31, 5'd0, 32'sd0, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_ROW, 5'd0, 5'd1, 32'sd131072, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_CELL, 5'd0, 5'd0, 32'sh80000000, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_CELL, 5'd1, 5'd0, 32'sh7fffffff, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_CELL, 5'd0, 5'd1, 32'sd100, 32'sd0, 32'sd0);
    send_beat(tb2d_pkg::OP_WR_CELL, 5'd1, 5'd1, -32'sd7, 32'sd0, 32'sd0);
    lookup(32'sh80000000, 32'sh80000000);
    lookup(32'sh7fffffff, 32'sh7fffffff);
    lookup(32'sd0, 32'sd65536);
    lookup(-32'sd65536, 32'sd131072);
    lookup(32'sd12345, -32'sd1);
    // Zero span on the column axis.
    send_beat(tb2d_pkg::OP_WR_COL, 5'd1, 5'd0, -32'sd65536, 32'sd0, 32'sd0);
    lookup(32'sd0, 32'sd65536);
    // Descending column axis.
    send_beat(tb2d_pkg::OP_WR_COL, 5'd0, 5'd0, 32'sd65536, 32'sd0, 32'sd0);
    lookup(32'sd0, 32'sd70000);
    lookup(32'sd65536, 32'sd1);
    // A cell written at the top corner of storage.
    send_beat(tb2d_pkg::OP_WR_CELL, 5'd31, 5'd31, 32'sh7fffffff, 32'sd0, 32'sd0);

    // Random phases across count settings, both out-of-range extremes included.
    col_settings = '{6'd2, 6'd0, 6'd63, 6'd3, 6'd1, 6'd17, 6'd32, 6'd5};
    row_settings = '{6'd2, 6'd1, 6'd2, 6'd63, 6'd0, 6'd9, 6'd3, 6'd7};
    for (int p = 0; p < 8; p++) begin
      write_count(tb2d_pkg::CFG_COL_COUNT, col_settings[p]);
      write_count(tb2d_pkg::CFG_ROW_COUNT, row_settings[p]);
      load_region();
      if (p == 7) quiet = 1;
      random_items(150);
    end

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d table writes, %0d checked lookups, %0d count writes.",
             sb.writes_seen, sb.lookups_checked, configs_done);
    $display("Count settings spanned 0 through 63 on both axes.");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
